>>> rtl/afsvf_pkg.sv
package afsvf_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_BITS = 16;
	localparam int OPND_W = WORD_W + 1;
	localparam int PROD_W = 2 * OPND_W;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 18;
	localparam int COEF_W = 17;
	localparam int DAMP_W = 18;
	localparam int MODE_W = 2;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [OPND_W-1:0] opnd_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [DAMP_W-1:0] damp_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOW  = 2'd0,
		MODE_BAND = 2'd1,
		MODE_HIGH = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA_ATTACK  = 4'd0,
		REG_BETA_ATTACK   = 4'd1,
		REG_ALPHA_RELEASE = 4'd2,
		REG_BETA_RELEASE  = 4'd3,
		REG_SWEEP_SPAN    = 4'd4,
		REG_SWEEP_BASE    = 4'd5,
		REG_DAMPING       = 4'd6,
		REG_FILTER_MODE   = 4'd7
	} reg_idx_t;

	typedef struct packed {
		coef_t alpha_attack;
		coef_t beta_attack;
		coef_t alpha_release;
		coef_t beta_release;
		coef_t sweep_span;
		coef_t sweep_base;
		damp_t damping;
		mode_t filter_mode;
	} cfg_regs_t;

	// One entry per multiply of the per-sample recurrence, in issue order.
	typedef enum logic [3:0] {
		STEP_PEAK_FB  = 4'd0,
		STEP_PEAK_IN  = 4'd1,
		STEP_ENV_FB   = 4'd2,
		STEP_ENV_IN   = 4'd3,
		STEP_PHASE    = 4'd4,
		STEP_SQUARE   = 4'd5,
		STEP_CUBIC    = 4'd6,
		STEP_SINE     = 4'd7,
		STEP_DAMP     = 4'd8,
		STEP_BAND     = 4'd9,
		STEP_LOW      = 4'd10
	} step_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_MUL  = 2'd1,
		ST_ACC  = 2'd2,
		ST_OUT  = 2'd3
	} state_t;

	typedef struct packed {
		logic  idle;
		logic  mul_en;
		logic  acc_en;
		logic  out_load;
		step_t step;
	} ctrl_t;

	// One in Q format, and minus one sixth truncated as in the sine polynomial.
	localparam word_t ONE_Q = word_t'(64'd1 << FRAC_BITS);
	localparam word_t SINE_K = word_t'(-((64'd1 << FRAC_BITS) / 6));

endpackage

>>> rtl/afsvf_ifs.sv
interface afsvf_sample_if;
	logic valid;
	logic ready;
	afsvf_pkg::word_t sample;
	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface afsvf_filt_if;
	logic valid;
	logic ready;
	afsvf_pkg::word_t filtered;
	modport source(output valid, output filtered, input ready);
	modport sink(input valid, input filtered, output ready);
endinterface

interface afsvf_cfg_if;
	logic valid;
	logic ready;
	afsvf_pkg::cfg_idx_t index;
	afsvf_pkg::cfg_data_t data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> rtl/afsvf_cfg.sv
module afsvf_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	afsvf_cfg_if.sink             cfg,
	output afsvf_pkg::cfg_regs_t  regs
);
	import afsvf_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.alpha_attack  <= coef_t'(64880);
			regs_q.beta_attack   <= coef_t'(656);
			regs_q.alpha_release <= coef_t'(64880);
			regs_q.beta_release  <= coef_t'(656);
			regs_q.sweep_span    <= '0;
			regs_q.sweep_base    <= '0;
			regs_q.damping       <= damp_t'(13107);
			regs_q.filter_mode   <= MODE_BAND;
		end else if (cfg.valid) begin
			// Indexes past the last register are dropped.
			unique case (cfg.index)
				REG_ALPHA_ATTACK:  regs_q.alpha_attack  <= cfg.data[COEF_W-1:0];
				REG_BETA_ATTACK:   regs_q.beta_attack   <= cfg.data[COEF_W-1:0];
				REG_ALPHA_RELEASE: regs_q.alpha_release <= cfg.data[COEF_W-1:0];
				REG_BETA_RELEASE:  regs_q.beta_release  <= cfg.data[COEF_W-1:0];
				REG_SWEEP_SPAN:    regs_q.sweep_span    <= cfg.data[COEF_W-1:0];
				REG_SWEEP_BASE:    regs_q.sweep_base    <= cfg.data[COEF_W-1:0];
				REG_DAMPING:       regs_q.damping       <= cfg.data[DAMP_W-1:0];
				REG_FILTER_MODE:   regs_q.filter_mode   <= mode_t'(cfg.data[MODE_W-1:0]);
				default: ;
			endcase
		end
	end
endmodule

>>> rtl/afsvf_mul.sv
module afsvf_mul (
	input  logic               clk,
	input  logic               en,
	input  afsvf_pkg::opnd_t   a,
	input  afsvf_pkg::opnd_t   b,
	output afsvf_pkg::word_t   prod
);
	import afsvf_pkg::*;

	logic signed [PROD_W-1:0] full;
	word_t prod_q;

	// Dropping the low fraction bits of a two's complement product floors it.
	assign full = PROD_W'(a) * PROD_W'(b);
	assign prod = prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= full[FRAC_BITS+WORD_W-1:FRAC_BITS];
		end
	end
endmodule

>>> rtl/afsvf_seq.sv
module afsvf_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              out_free,
	output afsvf_pkg::ctrl_t  ctrl
);
	import afsvf_pkg::*;

	state_t state_q, state_d;
	step_t  step_q, step_d;

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_MUL;
					step_d  = STEP_PEAK_FB;
				end
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (step_q == STEP_LOW) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_MUL;
					step_d  = step_t'(step_q + 4'd1);
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.idle     = (state_q == ST_IDLE);
		ctrl.mul_en   = (state_q == ST_MUL);
		ctrl.acc_en   = (state_q == ST_ACC);
		ctrl.out_load = (state_q == ST_OUT) && out_free;
		ctrl.step     = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_PEAK_FB;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end
endmodule

>>> rtl/auto_wah_envelope_svf.sv
// Envelope-controlled state-variable filter for fixed-point audio.
// Samples arrive as beats on the audio channel; each one yields exactly one
// filtered sample as a beat on the result channel. Coefficients and the
// filter mode are written through the cfg channel, which is always ready and
// should only be used while no sample is in flight.
// A sample is worked through eleven fixed-point multiplies on one shared
// 33 by 33 bit multiplier. Each multiply has two steps: the product is formed
// and registered, then folded into the filter state. After the last multiply
// the result is loaded into the output register, and a new sample is taken
// in the cycle after the result is loaded, so the block does not take a new
// sample before it is through with the last one. The shared multiplier and
// its product register make it work on one sample at a time.
// If the receiver stalls, the finished result sits in the output register
// and the block holds the next result in its sequencer until that register
// frees up; the input side is taken again once the pending result has moved.
// Reset clears the sequencer, the filter and envelope state, the output valid
// flag and loads the default coefficient set.
module auto_wah_envelope_svf (
	input  logic       clk,
	input  logic       arst_n,
	afsvf_cfg_if.sink  cfg,
	afsvf_sample_if.sink audio,
	afsvf_filt_if.source result
);
	import afsvf_pkg::*;

	cfg_regs_t regs;
	ctrl_t     ctrl;
	opnd_t     op_a, op_b;
	word_t     prod;
	word_t     t_sum;
	logic      out_free;

	// Working registers for the sample in flight.
	word_t x_q, r_q, acc_q, phase_q, tmp_q, f_q, hp_q;
	// State carried from sample to sample.
	word_t peak_q, env_q, band_q, low_q;
	word_t filtered_q;
	logic  out_valid_q;

	afsvf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// The output register is free when empty or being emptied this cycle.
	assign out_free = !out_valid_q || result.ready;

	afsvf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (audio.valid),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	assign audio.ready = ctrl.idle;

	// Operand selection for the shared multiplier. Coefficients are unsigned
	// and are zero extended; words are sign extended by one bit.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (ctrl.step)
			STEP_PEAK_FB: begin
				op_a = {16'b0, regs.alpha_release};
				op_b = {peak_q[WORD_W-1], peak_q};
			end
			STEP_PEAK_IN: begin
				op_a = {16'b0, regs.beta_release};
				op_b = {r_q[WORD_W-1], r_q};
			end
			STEP_ENV_FB: begin
				op_a = {16'b0, regs.alpha_attack};
				op_b = {env_q[WORD_W-1], env_q};
			end
			STEP_ENV_IN: begin
				op_a = {16'b0, regs.beta_attack};
				op_b = {peak_q[WORD_W-1], peak_q};
			end
			STEP_PHASE: begin
				op_a = {env_q[WORD_W-1], env_q};
				op_b = {16'b0, regs.sweep_span};
			end
			STEP_SQUARE: begin
				op_a = {phase_q[WORD_W-1], phase_q};
				op_b = {phase_q[WORD_W-1], phase_q};
			end
			STEP_CUBIC: begin
				op_a = {SINE_K[WORD_W-1], SINE_K};
				op_b = {tmp_q[WORD_W-1], tmp_q};
			end
			STEP_SINE: begin
				op_a = {phase_q[WORD_W-1], phase_q};
				op_b = {tmp_q[WORD_W-1], tmp_q};
			end
			STEP_DAMP: begin
				op_a = {15'b0, regs.damping};
				op_b = {band_q[WORD_W-1], band_q};
			end
			STEP_BAND: begin
				op_a = {f_q[WORD_W-1], f_q};
				op_b = {hp_q[WORD_W-1], hp_q};
			end
			STEP_LOW: begin
				op_a = {f_q[WORD_W-1], f_q};
				op_b = {band_q[WORD_W-1], band_q};
			end
			default: ;
		endcase
	end

	afsvf_mul u_mul (
		.clk  (clk),
		.en   (ctrl.mul_en),
		.a    (op_a),
		.b    (op_b),
		.prod (prod)
	);

	// Release detector candidate: the decayed peak plus the scaled input.
	assign t_sum = acc_q + prod;

	// Sample capture. The most negative sample rectifies to itself, which
	// the wrapping negate gives naturally.
	always_ff @(posedge clk) begin
		if (audio.valid && audio.ready) begin
			x_q <= audio.sample;
			r_q <= audio.sample[WORD_W-1] ? -audio.sample : audio.sample;
		end
	end

	// Scratch registers, updated in the fold cycle of the multiplies that feed them.
	always_ff @(posedge clk) begin
		if (ctrl.acc_en) begin
			unique case (ctrl.step)
				STEP_PEAK_FB: acc_q   <= prod;
				STEP_ENV_FB:  acc_q   <= prod;
				STEP_PHASE:   phase_q <= prod + word_t'(regs.sweep_base);
				STEP_SQUARE:  tmp_q   <= prod;
				STEP_CUBIC:   tmp_q   <= ONE_Q + prod;
				STEP_SINE:    f_q     <= prod <<< 1;
				STEP_DAMP:    hp_q    <= x_q - low_q - prod;
				default: ;
			endcase
		end
	end

	// Envelope and filter state, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			env_q  <= '0;
			band_q <= '0;
			low_q  <= '0;
		end else if (ctrl.acc_en) begin
			unique case (ctrl.step)
				STEP_PEAK_IN: peak_q <= (r_q > t_sum) ? r_q : t_sum;
				STEP_ENV_IN:  env_q  <= acc_q + prod;
				STEP_BAND:    band_q <= band_q + prod;
				STEP_LOW:     low_q  <= low_q + prod;
				default: ;
			endcase
		end
	end

	// Output register. The reserved mode code reads as bandpass.
	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			unique case (regs.filter_mode)
				MODE_LOW:  filtered_q <= low_q;
				MODE_HIGH: filtered_q <= hp_q;
				default:   filtered_q <= band_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.filtered = filtered_q;

endmodule

>>> test/auto_wah_envelope_svf_tb.sv
module auto_wah_envelope_svf_tb;
	import afsvf_pkg::*;

	// Length of the reset, which is held before the first beat is offered.
	localparam int RESET_CYCLES = 11;
	// The settle time at the end leaves room for a full computation of the block
	// and more, so that a stray extra beat would still be caught.
	localparam int SETTLE_CYCLES = 48;
	// The watchdog fires after this many cycles without a single beat on any
	// channel. The worst correct case is a full computation, a receiver stall
	// and a sender gap together, so this limit is many times what a healthy run
	// can produce.
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 100;

	// Register indexes past the end of the map; writes to them are dropped.
	localparam cfg_idx_t IDX_SPARE_LO = cfg_idx_t'(8);
	localparam cfg_idx_t IDX_SPARE_HI = cfg_idx_t'(15);
	localparam cfg_data_t DATA_ALL_ONES = '1;
	localparam cfg_data_t DATA_ZERO = '0;

	localparam word_t WORD_MAX = word_t'(32'h7FFF_FFFF);
	localparam word_t WORD_MIN = word_t'(32'h8000_0000);

	// One in Q format, and the sine polynomial's cubic weight: minus one sixth,
	// truncated toward zero before the sign is applied.
	localparam longint Q_ONE = longint'(1) << FRAC_BITS;
	localparam longint Q_SIXTH_NEG = -((longint'(1) << FRAC_BITS) / 6);

	// One row of the directed table: either a register write, or a sample with
	// an optional hand-computed result. Rows without one use the predictor.
	typedef struct packed {
		logic      is_cfg;
		cfg_idx_t  idx;
		cfg_data_t data;
		word_t     smp;
		logic      typed;
		word_t     want;
	} dir_row_t;

	// How the receiver handles the result channel for a while.
	typedef enum int {
		RX_FLOW,
		RX_COIN,
		RX_BURSTY
	} rx_style_t;

	logic clk;
	logic arst_n;

	afsvf_cfg_if    cfg_ch();
	afsvf_sample_if audio_ch();
	afsvf_filt_if   res_ch();

	auto_wah_envelope_svf u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.audio  (audio_ch),
		.result (res_ch)
	);

	// Shadow copy of the register file and of the four state words of the
	// envelope follower and the filter, kept in step with the block.
	cfg_regs_t cfg_shadow;
	word_t env_peak;
	word_t env_level;
	word_t svf_low;
	word_t svf_band;

	// Filtered samples the block still owes, oldest first.
	word_t filt_expect[$];
	dir_row_t dir_rows[$];
	int unsigned err_count;
	int unsigned idle_cycles;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Fixed-point product: full-precision multiply, then an arithmetic shift,
	// which rounds toward minus infinity, and a wrap to the word width.
	function automatic word_t qmul(longint a, longint b);
		longint prod;
		prod = a * b;
		return word_t'(prod >>> FRAC_BITS);
	endfunction

	function automatic void shadow_reset();
		cfg_shadow.alpha_attack = coef_t'(64880);
		cfg_shadow.beta_attack = coef_t'(656);
		cfg_shadow.alpha_release = coef_t'(64880);
		cfg_shadow.beta_release = coef_t'(656);
		cfg_shadow.sweep_span = coef_t'(0);
		cfg_shadow.sweep_base = coef_t'(0);
		cfg_shadow.damping = damp_t'(13107);
		cfg_shadow.filter_mode = MODE_BAND;
		env_peak = '0;
		env_level = '0;
		svf_low = '0;
		svf_band = '0;
	endfunction

	// A register keeps only the bits of its own width; an index outside the
	// map leaves everything as it was.
	function automatic void shadow_write(cfg_idx_t idx, cfg_data_t data);
		case (idx)
		REG_ALPHA_ATTACK: cfg_shadow.alpha_attack = data[COEF_W-1:0];
		REG_BETA_ATTACK: cfg_shadow.beta_attack = data[COEF_W-1:0];
		REG_ALPHA_RELEASE: cfg_shadow.alpha_release = data[COEF_W-1:0];
		REG_BETA_RELEASE: cfg_shadow.beta_release = data[COEF_W-1:0];
		REG_SWEEP_SPAN: cfg_shadow.sweep_span = data[COEF_W-1:0];
		REG_SWEEP_BASE: cfg_shadow.sweep_base = data[COEF_W-1:0];
		REG_DAMPING: cfg_shadow.damping = data[DAMP_W-1:0];
		REG_FILTER_MODE: cfg_shadow.filter_mode = mode_t'(data[MODE_W-1:0]);
		default: ;
		endcase
	endfunction

	// Advances the envelope follower and the filter by one sample and returns
	// the output that the current mode selects.
	function automatic word_t svf_predict(word_t x);
		word_t mag;
		word_t cand;
		word_t phase;
		word_t sq;
		word_t inner;
		word_t sine;
		word_t tune;
		word_t hp;
		// The most negative sample rectifies to itself and stays negative.
		mag = (x < 0) ? -x : x;
		cand = qmul(cfg_shadow.alpha_release, env_peak) +
			qmul(cfg_shadow.beta_release, mag);
		env_peak = (mag > cand) ? mag : cand;
		env_level = qmul(cfg_shadow.alpha_attack, env_level) +
			qmul(cfg_shadow.beta_attack, env_peak);
		phase = qmul(env_level, cfg_shadow.sweep_span) + word_t'(cfg_shadow.sweep_base);
		sq = qmul(phase, phase);
		inner = word_t'(Q_ONE) + qmul(Q_SIXTH_NEG, sq);
		sine = qmul(phase, inner);
		tune = sine <<< 1;
		hp = x - svf_low - qmul(cfg_shadow.damping, svf_band);
		svf_band = svf_band + qmul(tune, hp);
		svf_low = svf_low + qmul(tune, svf_band);
		case (cfg_shadow.filter_mode)
		MODE_LOW: return svf_low;
		MODE_HIGH: return hp;
		// The spare mode code falls back to bandpass, like the reset mode.
		default: return svf_band;
		endcase
	endfunction

	// Audio-like samples dominate: most are scaled-down random values, some
	// span the full word, and a few sit exactly on the extremes or at and around zero.
	function automatic word_t gen_sample();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 4))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return word_t'(0);
			3: return word_t'(-1);
			default: return word_t'(1);
			endcase
		end
		if (pick <= 3)
			return word_t'($urandom);
		return word_t'($urandom) >>> $urandom_range(11, 24);
	endfunction

	function automatic void add_cfg_row(cfg_idx_t idx, cfg_data_t data);
		dir_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.data = data;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_smp_row(word_t smp, logic typed, word_t want);
		dir_row_t row;
		row = '0;
		row.smp = smp;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	// Offers one sample beat at the current falling edge and returns at the
	// falling edge after it was taken, with valid still high. The caller then
	// either offers the next sample or lowers valid, so valid is assigned only
	// once per time step.
	task automatic send_sample(word_t smp, logic typed, word_t want);
		word_t model_out;
		audio_ch.valid <= 1'b1;
		audio_ch.sample <= smp;
		do @(posedge clk); while (audio_ch.ready !== 1'b1);
		model_out = svf_predict(smp);
		filt_expect.push_back(typed ? want : model_out);
		@(negedge clk);
	endtask

	task automatic pause_samples(int unsigned cycles);
		audio_ch.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Stops offering samples and waits until every owed result has been taken.
	task automatic drain();
		audio_ch.valid <= 1'b0;
		while (filt_expect.size() != 0)
			@(negedge clk);
	endtask

	// One register write beat. It starts one falling edge later and lowers
	// valid itself, so back-to-back writes never assign valid twice in a step.
	task automatic write_cfg(cfg_idx_t idx, cfg_data_t data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		shadow_write(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Programs every register for one phase of random stimulus. The first two
	// phases pin all registers to their lowest and highest codes; the rest
	// alternate between musically sensible settings and arbitrary ones.
	task automatic program_phase(int unsigned ph);
		cfg_data_t v_aa, v_ba, v_ar, v_br, v_span, v_base, v_damp, v_mode;
		if (ph == 0) begin
			v_aa = DATA_ZERO; v_ba = DATA_ZERO; v_ar = DATA_ZERO; v_br = DATA_ZERO;
			v_span = DATA_ZERO; v_base = DATA_ZERO; v_damp = DATA_ZERO;
			v_mode = cfg_data_t'(MODE_LOW);
		end else if (ph == 1) begin
			v_aa = DATA_ALL_ONES; v_ba = DATA_ALL_ONES;
			v_ar = DATA_ALL_ONES; v_br = DATA_ALL_ONES;
			v_span = DATA_ALL_ONES; v_base = DATA_ALL_ONES; v_damp = DATA_ALL_ONES;
			v_mode = cfg_data_t'(MODE_RSVD);
		end else if (ph % 2 == 0) begin
			// Smoothers whose two weights add up to one, a moderate sweep.
			v_aa = cfg_data_t'($urandom_range(60000, 65536));
			v_ba = cfg_data_t'(65536) - v_aa;
			v_ar = cfg_data_t'($urandom_range(60000, 65536));
			v_br = cfg_data_t'(65536) - v_ar;
			v_span = cfg_data_t'($urandom_range(0, 65536));
			v_base = cfg_data_t'($urandom_range(0, 16384));
			v_damp = cfg_data_t'($urandom_range(0, 131072));
			v_mode = cfg_data_t'($urandom_range(0, 3));
		end else begin
			v_aa = cfg_data_t'($urandom); v_ba = cfg_data_t'($urandom);
			v_ar = cfg_data_t'($urandom); v_br = cfg_data_t'($urandom);
			v_span = cfg_data_t'($urandom); v_base = cfg_data_t'($urandom);
			v_damp = cfg_data_t'($urandom);
			v_mode = cfg_data_t'($urandom);
		end
		write_cfg(REG_ALPHA_ATTACK, v_aa);
		write_cfg(REG_BETA_ATTACK, v_ba);
		write_cfg(REG_ALPHA_RELEASE, v_ar);
		write_cfg(REG_BETA_RELEASE, v_br);
		write_cfg(REG_SWEEP_SPAN, v_span);
		write_cfg(REG_SWEEP_BASE, v_base);
		write_cfg(REG_DAMPING, v_damp);
		write_cfg(REG_FILTER_MODE, v_mode);
		// A write to an index past the map must leave all of the above alone.
		if (ph % 2 == 1)
			write_cfg(($urandom_range(0, 1) == 0) ? IDX_SPARE_LO : IDX_SPARE_HI,
				cfg_data_t'($urandom));
	endtask

	// Receiver. It changes its manner after each stretch of random length: always
	// ready, ready on a coin toss, or mostly ready with occasional long stalls.
	// That way stalls land on every stage of the block's work, and there are long
	// stretches with no stall at all.
	initial begin : rx_drive
		rx_style_t style;
		int unsigned style_left;
		int unsigned hold;
		res_ch.ready = 1'b0;
		style = RX_FLOW;
		style_left = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (style_left == 0) begin
				style = rx_style_t'($urandom_range(0, 2));
				style_left = $urandom_range(50, 400);
			end
			style_left--;
			case (style)
			RX_FLOW: res_ch.ready <= 1'b1;
			RX_COIN: res_ch.ready <= 1'($urandom_range(0, 1));
			default: begin
				if (hold != 0) begin
					hold--;
					res_ch.ready <= 1'b0;
				end else if ($urandom_range(0, 7) == 0) begin
					hold = $urandom_range(1, 40);
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= 1'b1;
				end
			end
			endcase
		end
	end

	// Result checker and watchdog. Every result beat is matched against the
	// oldest owed value; the watchdog restarts on a beat on any channel.
	always @(posedge clk) begin : res_check
		word_t want;
		if (arst_n) begin
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				if (filt_expect.size() == 0) begin
					err_count++;
					$display("%0t: filtered beat 0x%08h with no sample owed", $time,
						res_ch.filtered);
				end else begin
					want = filt_expect.pop_front();
					if (res_ch.filtered !== want) begin
						err_count++;
						$display("%0t: filtered mismatch: expected 0x%08h (%0d), got 0x%08h (%0d)",
							$time, want, want, res_ch.filtered, res_ch.filtered);
					end
				end
			end
			if ((res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
				(audio_ch.valid === 1'b1 && audio_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("auto_wah_envelope_svf verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned n;
		int unsigned burst;
		int unsigned gap;
		dir_row_t row;
		err_count = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		audio_ch.valid = 1'b0;
		audio_ch.sample = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		shadow_reset();

		// Directed table. Right after reset the sweep span and base are zero,
		// so the tuning coefficient is zero and the filter state never moves:
		// bandpass and lowpass stay at zero and highpass passes the sample
		// straight through. Those rows carry their result by hand.
		add_smp_row(WORD_MAX, 1'b1, word_t'(0));
		add_smp_row(WORD_MIN, 1'b1, word_t'(0));
		add_cfg_row(REG_FILTER_MODE, cfg_data_t'(MODE_HIGH));
		add_smp_row(WORD_MIN, 1'b1, WORD_MIN);
		add_smp_row(WORD_MAX, 1'b1, WORD_MAX);
		add_smp_row(word_t'(0), 1'b1, word_t'(0));
		add_smp_row(word_t'(-1), 1'b1, word_t'(-1));
		// The spare mode code reads back as bandpass.
		add_cfg_row(REG_FILTER_MODE, cfg_data_t'(MODE_RSVD));
		add_smp_row(word_t'(32'h1234_5678), 1'b1, word_t'(0));
		add_cfg_row(REG_FILTER_MODE, cfg_data_t'(MODE_LOW));
		add_smp_row(WORD_MIN, 1'b1, word_t'(0));
		// Writes past the register map are dropped; lowpass must stay selected.
		add_cfg_row(IDX_SPARE_LO, DATA_ALL_ONES);
		add_cfg_row(IDX_SPARE_HI, DATA_ALL_ONES);
		add_smp_row(WORD_MAX, 1'b1, word_t'(0));
		// Now open up the sweep. Codes above the nominal range are kept within
		// the register width and used as they are.
		add_cfg_row(REG_SWEEP_SPAN, DATA_ALL_ONES);
		add_cfg_row(REG_SWEEP_BASE, DATA_ALL_ONES);
		add_cfg_row(REG_DAMPING, DATA_ALL_ONES);
		add_cfg_row(REG_ALPHA_RELEASE, DATA_ALL_ONES);
		add_cfg_row(REG_BETA_RELEASE, cfg_data_t'(65536));
		add_cfg_row(REG_FILTER_MODE, cfg_data_t'(MODE_BAND));
		add_smp_row(WORD_MIN, 1'b0, '0);
		add_smp_row(WORD_MAX, 1'b0, '0);
		add_smp_row(word_t'(0), 1'b0, '0);
		add_smp_row(word_t'(1), 1'b0, '0);
		add_smp_row(word_t'(-1), 1'b0, '0);
		add_cfg_row(REG_FILTER_MODE, cfg_data_t'(MODE_HIGH));
		add_smp_row(WORD_MIN, 1'b0, '0);
		add_smp_row(WORD_MAX, 1'b0, '0);
		add_cfg_row(REG_FILTER_MODE, cfg_data_t'(MODE_LOW));
		add_smp_row(WORD_MAX, 1'b0, '0);
		add_smp_row(WORD_MIN, 1'b0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.is_cfg) begin
				drain();
				write_cfg(row.idx, row.data);
			end else begin
				send_sample(row.smp, row.typed, row.want);
			end
		end

		// Random part. Each phase reprograms the block while it is idle and
		// then streams samples in bursts of random length. Gaps between bursts
		// are often zero and otherwise up to well past one computation, so the
		// sender's idle time falls on every stage of the block's sequence.
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			drain();
			program_phase(ph);
			n = 0;
			while (n < PHASE_ITEMS) begin
				burst = $urandom_range(1, 16);
				repeat (burst) begin
					send_sample(gen_sample(), 1'b0, '0);
					n++;
				end
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				if (gap != 0)
					pause_samples(gap);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("auto_wah_envelope_svf verification clean");
		else
			$display("auto_wah_envelope_svf verification failed");
		$finish;
	end

endmodule
